// File: sv/lcd_bitplane_capture_core_macros.svh
// ----------------------------------------------------------------------------
// lcd bitplane capture assertion macros
// concurrent assertion wrappers clocked on clk_i, reset by rst_ni
// ----------------------------------------------------------------------------
`ifndef LCD_BITPLANE_CAPTURE_CORE_MACROS_SVH
`define LCD_BITPLANE_CAPTURE_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// checked only out of reset
`define LCDBC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked on every edge, reset included
`define LCDBC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define LCDBC_ASSERT(lbl, prop, msg)
`define LCDBC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: sv/lcdbc_pkg.sv
// ----------------------------------------------------------------------------
// lcdbc_pkg
// shared constants and types of the lcd bitplane capture core
// ----------------------------------------------------------------------------
`default_nettype none

package lcdbc_pkg;

  // frame store geometry
  localparam int StoreWords = 8192;
  localparam int AddrW      = $clog2(StoreWords);
  localparam int PtrW       = $clog2(StoreWords + 1);
  localparam int IdxW       = 13;
  localparam int WordW      = 8;
  localparam int NibW       = 4;

  // timing
  localparam int StampW = 32;
  localparam int GuardW = 16;
  localparam logic [GuardW-1:0] GuardReset = GuardW'(9000);

  // command queue
  localparam int FifoDepth = 4;
  localparam int FifoAw    = $clog2(FifoDepth);
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  // stream payload widths
  localparam int InDataW  = 40;
  localparam int OutDataW = 24;

  // register file
  localparam int PaddrW = 3;
  localparam int PdataW = 32;
  localparam logic RegGuard = 1'b0;

  // classified sample, front to back
  typedef struct packed {
    logic             wrote;
    logic             restart;
    logic             ovf;
    logic             old_vld;
    logic             pol;
    logic [NibW-1:0]  nibble;
    logic [AddrW-1:0] addr;
  } cmd_t;

endpackage

`default_nettype wire

// File: sv/lcdbc_front.sv
// ----------------------------------------------------------------------------
// lcdbc_front
// edge and polarity detection, write pointer and fill mark, restart guard
// ----------------------------------------------------------------------------
`default_nettype none

`include "lcd_bitplane_capture_core_macros.svh"

module lcdbc_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          pix_clk_i,
  input  wire logic                          frame_pol_i,
  input  wire logic [lcdbc_pkg::NibW-1:0]    data_nibble_i,
  input  wire logic [lcdbc_pkg::StampW-1:0]  now_us_i,
  input  wire logic [lcdbc_pkg::GuardW-1:0]  guard_us_i,
  input  wire logic                          q_full_i,
  output logic                               push_o,
  output lcdbc_pkg::cmd_t                    cmd_o
);

  logic                          armed_q, armed_d;
  logic                          prev_clk_q, prev_clk_d;
  logic                          prev_pol_q, prev_pol_d;
  logic [lcdbc_pkg::StampW-1:0]  stamp_q, stamp_d;
  logic [lcdbc_pkg::PtrW-1:0]    ptr_q, ptr_d;
  logic [lcdbc_pkg::PtrW-1:0]    hwm_q, hwm_d;

  logic                          acc;
  logic                          active;
  logic                          rise;
  logic                          full;
  logic                          wr;
  logic                          restart;
  logic [lcdbc_pkg::StampW-1:0]  stamp_eff;
  logic [lcdbc_pkg::StampW-1:0]  elapsed;

  assign in_ready_o = !q_full_i;
  assign acc        = in_valid_i && in_ready_o;
  assign push_o     = acc;

  always_comb begin
    active    = armed_q || frame_pol_i;
    stamp_eff = armed_q ? stamp_q : now_us_i;
    elapsed   = now_us_i - stamp_eff;
    rise      = active && pix_clk_i && !prev_clk_q;
    full      = (ptr_q == lcdbc_pkg::PtrW'(lcdbc_pkg::StoreWords));
    wr        = rise && !full;
    restart   = active && (frame_pol_i != prev_pol_q) &&
                (elapsed > lcdbc_pkg::StampW'(guard_us_i));

    cmd_o.wrote   = wr;
    cmd_o.restart = restart;
    cmd_o.ovf     = rise && full;
    cmd_o.old_vld = (ptr_q < hwm_q);
    cmd_o.pol     = frame_pol_i;
    cmd_o.nibble  = data_nibble_i;
    cmd_o.addr    = ptr_q[lcdbc_pkg::AddrW-1:0];
  end

  always_comb begin
    armed_d    = armed_q;
    prev_clk_d = prev_clk_q;
    prev_pol_d = prev_pol_q;
    stamp_d    = stamp_q;
    ptr_d      = ptr_q;
    hwm_d      = hwm_q;
    if (acc && active) begin
      armed_d    = 1'b1;
      prev_clk_d = pix_clk_i;
      prev_pol_d = frame_pol_i;
      stamp_d    = (restart || !armed_q) ? now_us_i : stamp_q;
      // everything below the fill mark has been written since reset
      if (wr && (ptr_q == hwm_q)) begin
        hwm_d = hwm_q + lcdbc_pkg::PtrW'(1);
      end
      if (restart) begin
        ptr_d = '0;
      end else if (wr) begin
        ptr_d = ptr_q + lcdbc_pkg::PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q    <= 1'b0;
      prev_clk_q <= 1'b0;
      prev_pol_q <= 1'b0;
      stamp_q    <= '0;
      ptr_q      <= '0;
      hwm_q      <= '0;
    end else begin
      armed_q    <= armed_d;
      prev_clk_q <= prev_clk_d;
      prev_pol_q <= prev_pol_d;
      stamp_q    <= stamp_d;
      ptr_q      <= ptr_d;
      hwm_q      <= hwm_d;
    end
  end

  `LCDBC_ASSERT(a_ptr_within_fill, ptr_q <= hwm_q, "write pointer beyond fill mark")
  `LCDBC_ASSERT(a_fill_bounded, hwm_q <= lcdbc_pkg::PtrW'(lcdbc_pkg::StoreWords), "fill mark beyond store")
  `LCDBC_ASSERT(a_restart_rewinds, acc && restart |=> ptr_q == '0, "restart did not rewind pointer")

endmodule

`default_nettype wire

// File: sv/lcdbc_fifo.sv
// ----------------------------------------------------------------------------
// lcdbc_fifo
// short command queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module lcdbc_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire lcdbc_pkg::cmd_t  cmd_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  vld_o,
  output lcdbc_pkg::cmd_t       cmd_o
);

  lcdbc_pkg::cmd_t                 slot_q [lcdbc_pkg::FifoDepth];
  logic [lcdbc_pkg::FifoAw-1:0]    wptr_q, wptr_d;
  logic [lcdbc_pkg::FifoAw-1:0]    rptr_q, rptr_d;
  logic [lcdbc_pkg::FifoCntW-1:0]  cnt_q, cnt_d;
  logic                            do_push;
  logic                            do_pop;

  assign full_o  = (cnt_q == lcdbc_pkg::FifoCntW'(lcdbc_pkg::FifoDepth));
  assign vld_o   = (cnt_q != '0);
  assign cmd_o   = slot_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && vld_o;

  always_comb begin
    wptr_d = do_push ? wptr_q + lcdbc_pkg::FifoAw'(1) : wptr_q;
    rptr_d = do_pop ? rptr_q + lcdbc_pkg::FifoAw'(1) : rptr_q;
    cnt_d  = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + lcdbc_pkg::FifoCntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - lcdbc_pkg::FifoCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

// File: sv/lcdbc_back.sv
// ----------------------------------------------------------------------------
// lcdbc_back
// frame store read-modify-write and result register
// ----------------------------------------------------------------------------
`default_nettype none

`include "lcd_bitplane_capture_core_macros.svh"

module lcdbc_back (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           q_vld_i,
  input  wire lcdbc_pkg::cmd_t                q_cmd_i,
  output logic                                q_pop_o,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic                                wrote_o,
  output logic [lcdbc_pkg::IdxW-1:0]          word_index_o,
  output logic [1:0]                          pixel_a_o,
  output logic [1:0]                          pixel_b_o,
  output logic [1:0]                          pixel_c_o,
  output logic [1:0]                          pixel_d_o,
  output logic                                restarted_o,
  output logic                                overflow_o
);

  logic [lcdbc_pkg::WordW-1:0]  store_q [lcdbc_pkg::StoreWords];
  logic [lcdbc_pkg::WordW-1:0]  rd_q;

  lcdbc_pkg::cmd_t              s1_q;
  logic                         s1_vld_q, s1_vld_d;

  logic                         fwd_vld_q;
  logic [lcdbc_pkg::AddrW-1:0]  fwd_addr_q;
  logic [lcdbc_pkg::WordW-1:0]  fwd_data_q;

  logic                         out_vld_q, out_vld_d;
  logic                         out_wrote_q;
  logic [lcdbc_pkg::IdxW-1:0]   out_idx_q;
  logic [lcdbc_pkg::WordW-1:0]  out_pix_q;
  logic                         out_rst_q;
  logic                         out_ovf_q;

  logic                         out_ld;
  logic                         s1_adv;
  logic                         mem_we;
  logic [lcdbc_pkg::WordW-1:0]  old_word;
  logic [lcdbc_pkg::WordW-1:0]  new_word;

  assign out_ld  = !out_vld_q || out_ready_i;
  assign s1_adv  = s1_vld_q && out_ld;
  assign q_pop_o = q_vld_i && (!s1_vld_q || out_ld);
  assign mem_we  = s1_adv && s1_q.wrote;

  always_comb begin
    // a write made in the same cycle as the store read is not yet seen by the registered read
    if (!s1_q.old_vld) begin
      old_word = '0;
    end else if (fwd_vld_q && (fwd_addr_q == s1_q.addr)) begin
      old_word = fwd_data_q;
    end else begin
      old_word = rd_q;
    end
    for (int k = 0; k < lcdbc_pkg::NibW; k++) begin
      new_word[2*k +: 2] = s1_q.pol ? {s1_q.nibble[k], 1'b0}
                                    : (old_word[2*k +: 2] | {1'b0, s1_q.nibble[k]});
    end
  end

  always_comb begin
    s1_vld_d = s1_vld_q;
    if (q_pop_o) begin
      s1_vld_d = 1'b1;
    end else if (s1_adv) begin
      s1_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (s1_adv) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      fwd_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= s1_vld_d;
      out_vld_q <= out_vld_d;
      if (mem_we) begin
        fwd_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      s1_q <= q_cmd_i;
    end
    if (mem_we) begin
      fwd_addr_q <= s1_q.addr;
      fwd_data_q <= new_word;
    end
    if (s1_adv) begin
      out_wrote_q <= s1_q.wrote;
      out_idx_q   <= s1_q.wrote ? lcdbc_pkg::IdxW'(s1_q.addr) : '0;
      out_pix_q   <= s1_q.wrote ? new_word : '0;
      out_rst_q   <= s1_q.restart;
      out_ovf_q   <= s1_q.ovf;
    end
  end

  // frame store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_q[s1_q.addr] <= new_word;
    end
    if (q_pop_o) begin
      rd_q <= store_q[q_cmd_i.addr];
    end
  end

  assign out_valid_o  = out_vld_q;
  assign wrote_o      = out_wrote_q;
  assign word_index_o = out_idx_q;
  assign pixel_a_o    = out_pix_q[1:0];
  assign pixel_b_o    = out_pix_q[3:2];
  assign pixel_c_o    = out_pix_q[5:4];
  assign pixel_d_o    = out_pix_q[7:6];
  assign restarted_o  = out_rst_q;
  assign overflow_o   = out_ovf_q;

  `LCDBC_ASSERT(a_write_xor_ovf, out_vld_q |-> !(out_wrote_q && out_ovf_q), "write and overflow together")

endmodule

`default_nettype wire

// File: sv/lcd_bitplane_capture_core.sv
// ----------------------------------------------------------------------------
// lcd_bitplane_capture_core
// captures a sampled 4-bit lcd data bus into a 2-bit-per-pixel frame store
// ----------------------------------------------------------------------------
// one sample of the lcd pins (pixel clock, frame polarity, four data lines and
// a microsecond stamp) enters on the slave stream per cycle unless the command
// queue is full, and exactly one result per sample leaves on the master stream,
// in order. samples are taken at a sustained rate of one per clock while the
// queue has room; each sample is queued at the accepting edge, then its result
// is built from the registered store read and then waits in the
// result register while later samples keep flowing into a four-entry command
// queue. the front classifies each sample (pixel clock rise, polarity change,
// restart guard, pointer and fill mark), the back does the read-modify-write
// of the 8192 x 8 frame store. the store is not swept after reset: a fill mark
// tracks the words written since reset and anything at or above it reads as
// zero, so the block takes samples as soon as reset is released. guard_us
// sits at byte address 0 of the register port; the user must write it only
// while the stream is idle, and the block itself does not enforce this.
`default_nettype none

module lcd_bitplane_capture_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // register port
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [lcdbc_pkg::PaddrW-1:0]    paddr,
  input  wire logic [lcdbc_pkg::PdataW-1:0]    pwdata,
  output logic      [lcdbc_pkg::PdataW-1:0]    prdata,
  output logic                                 pready,
  // sample stream
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // pix_clk [0], data_nibble [4:1], now_us [36:5], zero fill [39:37]
  input  wire logic [lcdbc_pkg::InDataW-1:0]   s_axis_tdata,
  // frame_pol [0]
  input  wire logic                            s_axis_tuser,
  // result stream
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // word_index [12:0], pixel_a [14:13], pixel_b [16:15], pixel_c [18:17],
  // pixel_d [20:19], restarted [21], overflow [22], zero fill [23]
  output logic [lcdbc_pkg::OutDataW-1:0]       m_axis_tdata,
  // wrote [0]
  output logic                                 m_axis_tuser
);

  // guard register
  logic [lcdbc_pkg::GuardW-1:0]  guard_q, guard_d;
  logic                          reg_wr;
  logic                          reg_hit;

  // front to queue
  logic                          push;
  lcdbc_pkg::cmd_t               push_cmd;
  logic                          q_full;

  // queue to back
  logic                          q_vld;
  logic                          q_pop;
  lcdbc_pkg::cmd_t               q_cmd;

  // result fields
  logic                          wrote;
  logic [lcdbc_pkg::IdxW-1:0]    word_index;
  logic [1:0]                    pixel_a;
  logic [1:0]                    pixel_b;
  logic [1:0]                    pixel_c;
  logic [1:0]                    pixel_d;
  logic                          restarted;
  logic                          overflow;

  // register access, one register at word 0; the upper address bit selects
  // nothing and reads as zero
  assign pready  = 1'b1;
  assign reg_hit = (paddr[lcdbc_pkg::PaddrW-1] == lcdbc_pkg::RegGuard);
  assign reg_wr  = psel && penable && pwrite && pready && reg_hit;
  assign guard_d = reg_wr ? pwdata[lcdbc_pkg::GuardW-1:0] : guard_q;
  assign prdata  = reg_hit ? lcdbc_pkg::PdataW'(guard_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      guard_q <= lcdbc_pkg::GuardReset;
    end else begin
      guard_q <= guard_d;
    end
  end

  // front: classify each sample
  lcdbc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .pix_clk_i     (s_axis_tdata[0]),
    .frame_pol_i   (s_axis_tuser),
    .data_nibble_i (s_axis_tdata[4:1]),
    .now_us_i      (s_axis_tdata[36:5]),
    .guard_us_i    (guard_q),
    .q_full_i      (q_full),
    .push_o        (push),
    .cmd_o         (push_cmd)
  );

  // decoupling queue
  lcdbc_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .full_o (q_full),
    .pop_i  (q_pop),
    .vld_o  (q_vld),
    .cmd_o  (q_cmd)
  );

  // back: store update and result register
  lcdbc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_vld_i      (q_vld),
    .q_cmd_i      (q_cmd),
    .q_pop_o      (q_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .wrote_o      (wrote),
    .word_index_o (word_index),
    .pixel_a_o    (pixel_a),
    .pixel_b_o    (pixel_b),
    .pixel_c_o    (pixel_c),
    .pixel_d_o    (pixel_d),
    .restarted_o  (restarted),
    .overflow_o   (overflow)
  );

  // result packing, lowest field first
  assign m_axis_tdata = {1'b0, overflow, restarted, pixel_d, pixel_c, pixel_b, pixel_a,
                         word_index};
  assign m_axis_tuser = wrote;

endmodule

`default_nettype wire

// File: tb/lcd_bitplane_capture_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_bitplane_capture_core_tb
// self-checking bench for the lcd bitplane capture core: samples of the lcd
// pins are streamed in with random gaps and every result is compared field by
// field against a cycle-free model of the frame store and write pointer
// ----------------------------------------------------------------------------
module lcd_bitplane_capture_core_tb;

  localparam int unsigned CycleLimit = 200_000;
  localparam int          DrainCycles = 8;
  localparam int          PhaseItems  = 133;
  localparam logic [lcdbc_pkg::PaddrW-1:0] GuardAddr = lcdbc_pkg::PaddrW'(0);

  // one sample of the lcd pins
  typedef struct packed {
    logic                            pix_clk;
    logic                            frame_pol;
    logic [lcdbc_pkg::NibW-1:0]      nibble;
    logic [lcdbc_pkg::StampW-1:0]    now_us;
  } sample_t;

  // one result, pixel[0] is the first pixel of the group
  typedef struct packed {
    logic                            wrote;
    logic [lcdbc_pkg::IdxW-1:0]      word_index;
    logic [3:0][1:0]                 pixel;
    logic                            restarted;
    logic                            overflow;
  } capture_t;

  typedef struct packed {
    sample_t  smp;
    logic     fixed;
    capture_t res;
  } plan_row_t;

  // results read straight off the behavior
  localparam capture_t QuietRes  = '0;
  // arming sample with a rising clock and all data lines high, word 0
  localparam capture_t ArmRes    = {1'b1, 13'd0, 8'b1010_1010, 1'b0, 1'b0};
  // rewind with no pixel clock edge
  localparam capture_t RewindRes = {1'b0, 13'd0, 8'd0, 1'b1, 1'b0};

  logic                                clk_i         = 1'b0;
  logic                                rst_ni        = 1'b0;
  logic                                psel          = 1'b0;
  logic                                penable       = 1'b0;
  logic                                pwrite        = 1'b0;
  logic [lcdbc_pkg::PaddrW-1:0]        paddr         = '0;
  logic [lcdbc_pkg::PdataW-1:0]        pwdata        = '0;
  logic [lcdbc_pkg::PdataW-1:0]        prdata;
  logic                                pready;
  logic                                s_axis_tvalid = 1'b0;
  logic                                s_axis_tready;
  logic [lcdbc_pkg::InDataW-1:0]       s_axis_tdata  = '0;
  logic                                s_axis_tuser  = 1'b0;
  logic                                m_axis_tvalid;
  logic                                m_axis_tready = 1'b0;
  logic [lcdbc_pkg::OutDataW-1:0]      m_axis_tdata;
  logic                                m_axis_tuser;

  // model of the capture state
  logic [lcdbc_pkg::WordW-1:0]   frame_mirror [lcdbc_pkg::StoreWords];
  logic [lcdbc_pkg::PtrW-1:0]    mirror_ptr      = '0;
  logic                          mirror_prev_clk = 1'b0;
  logic                          mirror_prev_pol = 1'b0;
  logic [lcdbc_pkg::StampW-1:0]  mirror_stamp    = '0;
  logic                          mirror_armed    = 1'b0;
  logic [lcdbc_pkg::GuardW-1:0]  mirror_guard    = lcdbc_pkg::GuardReset;

  capture_t    pending_results [$];
  plan_row_t   directed_rows [$];
  logic [lcdbc_pkg::StampW-1:0] bus_time = '0;
  logic        steady   = 1'b0;
  int          err_cnt  = 0;
  int unsigned cycle_cnt = 0;

  lcd_bitplane_capture_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // hard stop in case the stream hangs
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // one sample through the capture state, returns the result it causes
  function automatic capture_t capture_sample(input sample_t smp);
    capture_t                      res;
    logic [lcdbc_pkg::WordW-1:0]   word;
    logic [lcdbc_pkg::WordW-1:0]   new_word;
    logic [1:0]                    px;
    logic [lcdbc_pkg::StampW-1:0]  elapsed;
    int                            k;
    res = '0;
    new_word = '0;
    // idle until polarity first seen high, nothing at all moves before
    if (!mirror_armed) begin
      if (!smp.frame_pol) return res;
      mirror_armed = 1'b1;
      mirror_stamp = smp.now_us;
    end
    if (smp.pix_clk && !mirror_prev_clk) begin
      if (mirror_ptr < lcdbc_pkg::PtrW'(lcdbc_pkg::StoreWords)) begin
        word = frame_mirror[mirror_ptr[lcdbc_pkg::AddrW-1:0]];
        for (k = 0; k < 4; k++) begin
          // high plane replaces the pixel, low plane ors into bit 0
          if (smp.frame_pol) px = {smp.nibble[k], 1'b0};
          else               px = word[2*k +: 2] | {1'b0, smp.nibble[k]};
          res.pixel[k] = px;
          new_word[2*k +: 2] = px;
        end
        frame_mirror[mirror_ptr[lcdbc_pkg::AddrW-1:0]] = new_word;
        res.wrote      = 1'b1;
        res.word_index = mirror_ptr[lcdbc_pkg::IdxW-1:0];
        mirror_ptr     = mirror_ptr + lcdbc_pkg::PtrW'(1);
      end else begin
        res.overflow = 1'b1;
      end
    end
    // rewind comes after the write, elapsed time wraps mod 2^32
    elapsed = smp.now_us - mirror_stamp;
    if (smp.frame_pol != mirror_prev_pol && elapsed > {16'd0, mirror_guard}) begin
      mirror_ptr    = '0;
      mirror_stamp  = smp.now_us;
      res.restarted = 1'b1;
    end
    mirror_prev_clk = smp.pix_clk;
    mirror_prev_pol = smp.frame_pol;
    return res;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  function automatic void plan_sample(input logic clk, input logic pol,
                                      input logic [lcdbc_pkg::NibW-1:0] nib,
                                      input logic [lcdbc_pkg::StampW-1:0] now,
                                      input logic fixed, input capture_t res);
    plan_row_t row;
    row.smp   = {clk, pol, nib, now};
    row.fixed = fixed;
    row.res   = res;
    directed_rows.push_back(row);
  endfunction

  task automatic check_result(input logic [lcdbc_pkg::OutDataW-1:0] td, input logic tu);
    capture_t want;
    capture_t got;
    int       k;
    got.wrote      = tu;
    got.word_index = td[12:0];
    for (k = 0; k < 4; k++) got.pixel[k] = td[13 + 2*k +: 2];
    got.restarted  = td[21];
    got.overflow   = td[22];
    if (pending_results.size() == 0) begin
      $error("result with no request pending: tdata %h tuser %b", td, tu);
      err_cnt++;
      return;
    end
    want = pending_results.pop_front();
    if (got.wrote !== want.wrote) begin
      $error("wrote: expected %0d, got %0d", want.wrote, got.wrote);
      err_cnt++;
    end
    if (got.word_index !== want.word_index) begin
      $error("word_index: expected %0d, got %0d", want.word_index, got.word_index);
      err_cnt++;
    end
    for (k = 0; k < 4; k++) begin
      if (got.pixel[k] !== want.pixel[k]) begin
        $error("pixel_%c: expected %0d, got %0d", 8'd97 + k, want.pixel[k], got.pixel[k]);
        err_cnt++;
      end
    end
    if (got.restarted !== want.restarted) begin
      $error("restarted: expected %0d, got %0d", want.restarted, got.restarted);
      err_cnt++;
    end
    if (got.overflow !== want.overflow) begin
      $error("overflow: expected %0d, got %0d", want.overflow, got.overflow);
      err_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata, m_axis_tuser);
  end

  // result side back-pressure
  initial begin : sink_ready
    int n;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
      n = pick_gap();
      if (n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
    end
  end

  // one request on the sample stream; valid stays up for a following request
  task automatic send_sample(input sample_t smp, input logic fixed, input capture_t fixed_res);
    int       gap;
    capture_t res;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    // zero fill, now_us, data_nibble, pix_clk
    s_axis_tdata  <= {3'b000, smp.now_us, smp.nibble, smp.pix_clk};
    s_axis_tuser  <= smp.frame_pol;
    do @(posedge clk_i); while (!s_axis_tready);
    res = capture_sample(smp);
    pending_results.push_back(fixed ? fixed_res : res);
  endtask

  // stop the stream and let every result come home before touching registers
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // write guard_us, then read it back in the following transfer
  task automatic program_guard(input logic [lcdbc_pkg::GuardW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= GuardAddr;
    pwdata  <= lcdbc_pkg::PdataW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    mirror_guard = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    if (prdata !== lcdbc_pkg::PdataW'(value)) begin
      $error("guard_us readback: expected %0d, got %0d", value, prdata);
      err_cnt++;
    end
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // frames of toggling pixel clock with occasional polarity flips; some flips
  // land right at the guard boundary, a few samples are arbitrary noise
  task automatic run_random(input int count);
    sample_t smp;
    repeat (count) begin
      smp.nibble = $urandom_range(0, 15);
      if ($urandom_range(0, 99) < 8) begin
        smp.pix_clk   = $urandom_range(0, 1);
        smp.frame_pol = $urandom_range(0, 1);
        bus_time      = $urandom;
      end else begin
        smp.pix_clk   = ($urandom_range(0, 99) < 88) ? ~mirror_prev_clk : mirror_prev_clk;
        smp.frame_pol = mirror_prev_pol;
        bus_time      = bus_time + $urandom_range(0, 3);
        if ($urandom_range(0, 99) < 5) begin
          smp.frame_pol = ~mirror_prev_pol;
          if ($urandom_range(0, 1) == 1)
            bus_time = mirror_stamp + {16'd0, mirror_guard} + $urandom_range(0, 2) - 1;
        end
      end
      smp.now_us = bus_time;
      send_sample(smp, 1'b0, QuietRes);
    end
  endtask

  initial begin : main
    plan_row_t row;
    foreach (frame_mirror[i]) frame_mirror[i] = '0;

    // not armed yet: low polarity is ignored, high clock included
    plan_sample(1'b1, 1'b0, 4'hF, 32'h0000_0000, 1'b1, QuietRes);
    plan_sample(1'b0, 1'b0, 4'hA, 32'hFFFF_FFFF, 1'b1, QuietRes);
    plan_sample(1'b1, 1'b0, 4'h5, 32'd12345,     1'b1, QuietRes);
    // arming sample counts its high clock as a rising edge
    plan_sample(1'b1, 1'b1, 4'hF, 32'd100,       1'b1, ArmRes);
    // clock held high, then low: no write
    plan_sample(1'b1, 1'b1, 4'h0, 32'd200,       1'b1, QuietRes);
    plan_sample(1'b0, 1'b1, 4'h5, 32'd300,       1'b1, QuietRes);
    plan_sample(1'b1, 1'b1, 4'h5, 32'd400,       1'b0, QuietRes);
    // polarity change well inside the guard window
    plan_sample(1'b0, 1'b0, 4'h0, 32'd500,       1'b0, QuietRes);
    plan_sample(1'b1, 1'b0, 4'hA, 32'd600,       1'b0, QuietRes);
    // elapsed exactly guard_us: no rewind
    plan_sample(1'b0, 1'b1, 4'h0, 32'd9100,      1'b0, QuietRes);
    // one past guard_us: rewind
    plan_sample(1'b0, 1'b0, 4'h0, 32'd9101,      1'b1, RewindRes);
    // low plane ors into the word written by the arming sample
    plan_sample(1'b1, 1'b0, 4'hF, 32'd9102,      1'b0, QuietRes);
    plan_sample(1'b0, 1'b1, 4'h0, 32'd9103,      1'b0, QuietRes);
    // clock edge and rewind in the same sample
    plan_sample(1'b1, 1'b0, 4'h3, 32'd20000,     1'b0, QuietRes);
    // restart stamp just below the wrap point
    plan_sample(1'b0, 1'b1, 4'h0, 32'hFFFF_F000, 1'b0, QuietRes);
    plan_sample(1'b1, 1'b1, 4'h9, 32'hFFFF_FFFF, 1'b0, QuietRes);
    // across the wrap: elapsed 8192, then 12288
    plan_sample(1'b0, 1'b0, 4'h6, 32'h0000_1000, 1'b0, QuietRes);
    plan_sample(1'b0, 1'b1, 4'hC, 32'h0000_2000, 1'b0, QuietRes);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // guard_us at its reset value for the directed part
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_sample(row.smp, row.fixed, row.res);
    end
    settle();

    bus_time = 32'h0000_3000;
    program_guard(16'd0);
    run_random(PhaseItems);
    settle();

    program_guard(16'hFFFF);
    run_random(PhaseItems);
    settle();

    // no idling on either side for a while
    steady = 1'b1;
    program_guard(16'($urandom_range(1, 400)));
    run_random(PhaseItems);
    settle();
    steady = 1'b0;

    program_guard(16'($urandom_range(0, 65535)));
    run_random(PhaseItems);
    settle();

    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
